@@ design/matf_pkg.sv @@
// ----------------------------------------------------------------------------
// matf_pkg
// Shared types and fixed field widths of the thermocouple moving-average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package matf_pkg;

  localparam int RAW_W       = 16;  // sensor word
  localparam int SAMPLE_W    = 13;  // quarter degrees taken from the sensor word
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int SCALE_SHIFT = 4;   // average reported times 16
  localparam int AVG_W       = 17;
  localparam int HELD_W      = 5;
  localparam int OUT_DATA_W  = 24;  // average_x16 and samples_held, padded to bytes

  // Commands from the controller to the datapath and the divider
  typedef struct packed {
    logic capture;    // latch the incoming request
    logic update;     // apply the sample to ring, sum and counters
    logic div_start;  // load the divider with sum * 16 and the fill count
    logic load_out;   // move the finished result into the output register
  } matf_cmd_t;

  typedef struct packed {
    logic div_done;
  } matf_status_t;

endpackage

`default_nettype wire

@@ design/matf_divider.sv @@
// ----------------------------------------------------------------------------
// matf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module matf_divider #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic      [NUM_W-1:0] quotient,
  output logic                  done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] steps;

  logic [DEN_W:0] rem_shift;
  logic [DEN_W:0] rem_diff;
  logic           fits;

  always_comb begin
    rem_shift = {rem, quo[NUM_W-1]};
    rem_diff  = rem_shift - {1'b0, den};
    fits      = rem_shift >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= CNT_W'(NUM_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
      if (steps == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (steps != '0) begin
      rem <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

@@ design/matf_datapath.sv @@
// ----------------------------------------------------------------------------
// matf_datapath
// Sample ring, running sum, counters, sticky error and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module matf_datapath #(
  parameter int WINDOW_DEPTH = 16,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5,
  parameter int SUM_W        = 17,
  parameter int NUM_W        = 21
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire matf_pkg::matf_cmd_t             cmd,
  input  wire logic                            read_failed,
  input  wire logic [matf_pkg::RAW_W-1:0]      raw_word,
  input  wire logic [NUM_W-1:0]                quotient,
  output logic      [NUM_W-1:0]                dividend,
  output logic      [CNT_W-1:0]                divisor,
  output logic      [matf_pkg::AVG_W-1:0]      average_x16,
  output logic                                 no_value,
  output logic      [matf_pkg::HELD_W-1:0]     samples_held
);

  localparam int PW = CNT_W + 1;

  logic [matf_pkg::SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  logic [matf_pkg::SAMPLE_W-1:0] oldest_data;

  logic                          failed;
  logic [matf_pkg::SAMPLE_W-1:0] sample;
  logic                          sticky_error;
  logic [IDX_W-1:0]              oldest_index;
  logic [CNT_W-1:0]              fill_count;
  logic [SUM_W-1:0]              running_sum;

  logic                          full;
  logic [PW-1:0]                 pos_raw;
  logic [IDX_W-1:0]              pos;
  logic [IDX_W-1:0]              oldest_inc;
  logic [SUM_W-1:0]              sum_next;
  logic                          ring_write;
  logic                          none;
  logic [CNT_W+matf_pkg::HELD_W-1:0] held_ext;

  always_comb begin
    full = fill_count == CNT_W'(WINDOW_DEPTH);
    // slot after the newest sample; when full it lands on the oldest one
    pos_raw = PW'(oldest_index) + PW'(fill_count);
    if (pos_raw >= PW'(WINDOW_DEPTH)) begin
      pos_raw = pos_raw - PW'(WINDOW_DEPTH);
    end
    pos = pos_raw[IDX_W-1:0];
    oldest_inc = (oldest_index == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_index + 1'b1;
    sum_next = running_sum - (full ? SUM_W'(oldest_data) : '0) + SUM_W'(sample);
    ring_write = cmd.update && !failed;
    none = sticky_error || (fill_count == '0);
    held_ext = {{matf_pkg::HELD_W{1'b0}}, fill_count};
  end

  // ring memory: one write port, one registered read port at the oldest slot
  always_ff @(posedge clk) begin
    if (ring_write) begin
      ring[pos] <= sample;
    end
    oldest_data <= ring[oldest_index];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      failed <= read_failed;
      sample <= raw_word[matf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_error <= 1'b0;
      oldest_index <= '0;
      fill_count   <= '0;
      running_sum  <= '0;
    end else if (cmd.update) begin
      if (failed) begin
        sticky_error <= 1'b1;
      end else begin
        running_sum <= sum_next;
        if (full) begin
          oldest_index <= oldest_inc;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_x16  <= none ? '0 : quotient[matf_pkg::AVG_W-1:0];
      no_value     <= none;
      samples_held <= held_ext[matf_pkg::HELD_W-1:0];
    end
  end

  assign dividend = {running_sum, {matf_pkg::SCALE_SHIFT{1'b0}}};
  assign divisor  = fill_count;

endmodule

`default_nettype wire

@@ design/matf_ctrl.sv @@
// ----------------------------------------------------------------------------
// matf_ctrl
// Sequencer for one request: update, divide, hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module matf_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  input  wire matf_pkg::matf_status_t  status,
  output matf_pkg::matf_cmd_t          cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = state == S_IDLE;
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/moving_average_thermocouple_filter.sv @@
// ----------------------------------------------------------------------------
// moving_average_thermocouple_filter
// Running mean of the last WINDOW_DEPTH good thermocouple reads.
// ----------------------------------------------------------------------------
// Each request is one sensor read; each gives exactly one result: the mean of
// the held samples in quarter degrees times 16 (truncated), the number of
// samples held, and a no-value flag that is set once any read has failed (until
// reset) or while no sample is held. One request is worked at a time, paced by
// the restoring divider that yields one quotient bit of sum * 16 / count per
// cycle; the sum is SUM_W = 13 + clog2(WINDOW_DEPTH) bits wide. The result
// sits in an output register, so the next request is taken while it waits to
// be read.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_thermocouple_filter #(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [matf_pkg::RAW_W-1:0]         s_tdata,   // raw_word
  input  wire logic                               s_tuser,   // read_failed
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [matf_pkg::OUT_DATA_W-1:0]    m_tdata,   // average_x16, samples_held
  output logic                                    m_tuser    // no_value
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = $clog2(matf_pkg::SAMPLE_MAX * WINDOW_DEPTH + 1);
  localparam int NUM_W = SUM_W + matf_pkg::SCALE_SHIFT;
  localparam int PAD_W = matf_pkg::OUT_DATA_W - matf_pkg::AVG_W - matf_pkg::HELD_W;

  matf_pkg::matf_cmd_t    cmd;
  matf_pkg::matf_status_t status;

  logic [NUM_W-1:0]              dividend;
  logic [NUM_W-1:0]              quotient;
  logic [CNT_W-1:0]              divisor;
  logic [matf_pkg::AVG_W-1:0]    average_x16;
  logic [matf_pkg::HELD_W-1:0]   samples_held;
  logic                          div_done;

  assign status.div_done = div_done;

  matf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  matf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W),
    .NUM_W        (NUM_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .read_failed  (s_tuser),
    .raw_word     (s_tdata),
    .quotient     (quotient),
    .dividend     (dividend),
    .divisor      (divisor),
    .average_x16  (average_x16),
    .no_value     (m_tuser),
    .samples_held (samples_held)
  );

  matf_divider #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign m_tdata = {{PAD_W{1'b0}}, samples_held, average_x16};

endmodule

`default_nettype wire
